FILE: src/des_round_function_f_assert.svh
// ----------------------------------------------------------------------------
// des_round_function_f_assert.svh
// Assertion macros shared by the DES round function RTL.
// ----------------------------------------------------------------------------
`ifndef DES_ROUND_FUNCTION_F_ASSERT_SVH
`define DES_ROUND_FUNCTION_F_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define DES_F_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("des_round_function_f: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define DES_F_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("des_round_function_f: assertion failed");

`endif

FILE: src/des_f_pkg.sv
// ----------------------------------------------------------------------------
// des_f_pkg
// Tables and bit-level helpers for the DES round function f.
// ----------------------------------------------------------------------------
package des_f_pkg;

    localparam int HalfW = 32;
    localparam int KeyW  = 48;

    typedef logic [HalfW-1:0] half_t;
    typedef logic [KeyW-1:0]  key_t;
    typedef logic [4:0]       bit_idx_t;

    // E table, entry k gives the LSB-based source bit of expanded bit k (MSB first)
    localparam bit_idx_t E_IDX [0:47] = '{
        5'd0,  5'd31, 5'd30, 5'd29, 5'd28, 5'd27,
        5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd23,
        5'd24, 5'd23, 5'd22, 5'd21, 5'd20, 5'd19,
        5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15,
        5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11,
        5'd12, 5'd11, 5'd10, 5'd9,  5'd8,  5'd7,
        5'd8,  5'd7,  5'd6,  5'd5,  5'd4,  5'd3,
        5'd4,  5'd3,  5'd2,  5'd1,  5'd0,  5'd31
    };

    // P table, same convention
    localparam bit_idx_t P_IDX [0:31] = '{
        5'd16, 5'd25, 5'd12, 5'd11, 5'd3,  5'd20, 5'd4,  5'd15,
        5'd31, 5'd17, 5'd9,  5'd6,  5'd27, 5'd14, 5'd1,  5'd22,
        5'd30, 5'd24, 5'd8,  5'd18, 5'd0,  5'd5,  5'd29, 5'd23,
        5'd13, 5'd19, 5'd2,  5'd26, 5'd10, 5'd21, 5'd28, 5'd7
    };

    // S-boxes S1..S8, [box][row][column]
    localparam logic [3:0] SBOX_TAB [0:7][0:3][0:15] = '{
        '{ '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
             4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
           '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
             4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
           '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
             4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
           '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
             4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13} },
        '{ '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
             4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
           '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
             4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
           '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
             4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
           '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
             4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9} },
        '{ '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
             4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
           '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
             4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
           '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
             4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
           '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
             4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12} },
        '{ '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
             4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
           '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
             4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
           '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
             4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
           '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
             4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14} },
        '{ '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
             4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
           '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
             4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
           '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
             4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
           '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
             4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3} },
        '{ '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
             4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
           '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
             4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
           '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
             4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
           '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
             4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13} },
        '{ '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
             4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
           '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
             4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
           '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
             4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
           '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
             4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12} },
        '{ '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
             4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
           '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
             4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
           '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
             4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
           '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
             4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11} }
    };

    // E expansion: pure wiring
    function automatic key_t e_expand(input half_t r);
        key_t e;
        e = '0;
        for (int k = 0; k < KeyW; k++)
        begin
            e[KeyW-1-k] = r[E_IDX[k]];
        end
        return e;
    endfunction

    // P permutation: pure wiring
    function automatic half_t p_permute(input half_t s);
        half_t p;
        p = '0;
        for (int k = 0; k < HalfW; k++)
        begin
            p[HalfW-1-k] = s[P_IDX[k]];
        end
        return p;
    endfunction

    // One S-box lookup: row from outer bits, column from middle four
    function automatic logic [3:0] sbox_lookup(input logic [2:0] box, input logic [5:0] grp);
        return SBOX_TAB[box][{grp[5], grp[0]}][grp[4:1]];
    endfunction

endpackage

FILE: src/des_round_function_f.sv
// ----------------------------------------------------------------------------
// des_round_function_f
// DES round function f: E expansion, subkey mix, S1..S8, P permutation.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: right_half and round_key are taken at a rising edge where
//   start is high and busy is low. busy is high only in the first cycle
//   after reset is released, then stays low; a word may be issued every
//   cycle.
//   Result word: f_result is valid for exactly one cycle while done is high.
//   Order: an accepted word is held in the input register, then the
//   result register takes the result. Throughput: one word
//   per cycle; the E/XOR/S-box/P path sits entirely between the two
//   registers.
//   Reset: rst_n is asynchronous, active low; it drops any word in flight,
//   clears done and sets busy. The data registers are not reset.
//   The receiver cannot stall; each result must be taken when done is high.
// ----------------------------------------------------------------------------
`include "des_round_function_f_assert.svh"

module des_round_function_f
    import des_f_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [HalfW-1:0]  right_half,
    input  logic [KeyW-1:0]   round_key,
    output logic              done,
    output logic [HalfW-1:0]  f_result
);

    logic  busy_reg;
    logic  in_valid_reg;
    logic  in_valid_next;
    half_t right_half_reg;
    key_t  round_key_reg;
    logic  done_reg;
    half_t f_result_reg;
    half_t f_result_next;
    key_t  mixed;
    half_t joined;
    logic  accept;

    assign accept        = start && !busy_reg;
    assign in_valid_next = accept;

    // Busy for one cycle out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            right_half_reg <= right_half;
            round_key_reg  <= round_key;
        end
    end

    // Expand and mix with subkey
    assign mixed = e_expand(right_half_reg) ^ round_key_reg;

    // S-box layer, S1 in the top nibble
    for (genvar g = 0; g < 8; g++)
    begin : g_sbox
        assign joined[HalfW-1-4*g -: 4] = sbox_lookup(3'(g), mixed[KeyW-1-6*g -: 6]);
    end

    assign f_result_next = p_permute(joined);

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            f_result_reg <= f_result_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign f_result = f_result_reg;

    // Checks
    `DES_F_ASSERT_NEXT(a_accept_to_done, accept, ##1 done_reg)
    `DES_F_ASSERT_NEXT(a_no_word_no_done, !in_valid_reg, !done_reg)
    `DES_F_ASSERT_NEXT(a_busy_blocks_accept, busy_reg, !in_valid_reg)
    `DES_F_ASSERT_IMPL(a_done_has_source, done_reg, $past(in_valid_reg))

endmodule
